// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the servo read transaction RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRV_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo read transaction assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SRV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo read transaction assertion failed");

`endif

// ===== rtl/srvrd_pkg.sv =====
// Package for the servo read transaction block: command codes, packet
// constants and the control/result structs between the top level and the reply unit.
// No dependencies.
`default_nettype none

package srvrd_pkg;

  typedef enum logic [1:0] {
    CMD_REQ  = 2'd0,
    CMD_RXB  = 2'd1,
    CMD_CHK  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic KIND_TX  = 1'b0;
  localparam logic KIND_CHK = 1'b1;

  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] PKT_LENGTH = 8'h04;
  localparam logic [7:0] INSTR_READ = 8'h02;
  localparam logic [7:0] READ_SIZE  = 8'h02;

  localparam int         REPLY_LEN   = 8;
  localparam int         STORE_BASE  = 2;
  localparam int         STORE_DEPTH = 6;
  localparam logic [2:0] LAST_TX_IDX = 3'(REPLY_LEN - 1);

  // Control pulses from the sequencer to the reply unit.
  typedef struct packed {
    logic clear;
    logic wr;
    logic chk;
  } rpl_ctl_t;

  // Check outcome; lost is the counter value after this check.
  typedef struct packed {
    logic        ok;
    logic [15:0] value;
    logic [15:0] lost;
  } rpl_res_t;

endpackage

`default_nettype wire

// ===== rtl/srvrd_reply.sv =====
// Reply store, running index, pending id and lost-reply counter with the
// checksum test. Depends on srvrd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module srvrd_reply
  import srvrd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire rpl_ctl_t   ctl,
  input  wire logic [7:0] new_id,
  input  wire logic [7:0] rx_byte,
  output rpl_res_t        res
);

  logic [7:0]  byte_r   [STORE_DEPTH];
  logic [7:0]  byte_nxt [STORE_DEPTH];
  logic [3:0]  idx_r,  idx_nxt;
  logic [7:0]  pid_r,  pid_nxt;
  logic [15:0] lost_r, lost_nxt;

  logic [2:0]  widx;
  logic        wr_en;
  logic        store_en;
  logic [7:0]  sum;
  logic        ok;
  logic [15:0] lost_inc;

  assign widx     = 3'(idx_r - 4'(STORE_BASE));
  assign wr_en    = ctl.wr && (idx_r < 4'(REPLY_LEN));
  assign store_en = wr_en && (idx_r >= 4'(STORE_BASE));

  // Checksum covers id, length, error, and the two data bytes.
  assign sum = byte_r[0] + byte_r[1] + byte_r[2] + byte_r[3] + byte_r[4];
  assign ok  = (~sum == byte_r[5]) && (byte_r[0] == pid_r);

  assign lost_inc = (!ok && lost_r != 16'hFFFF) ? lost_r + 16'd1 : lost_r;

  assign res.ok    = ok;
  assign res.value = ok ? {byte_r[4], byte_r[3]} : 16'd0;
  assign res.lost  = lost_inc;

  always_comb begin
    idx_nxt  = idx_r;
    pid_nxt  = pid_r;
    lost_nxt = lost_r;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      byte_nxt[i] = byte_r[i];
      if (ctl.clear) begin
        byte_nxt[i] = 8'd0;
      end else if (store_en && widx == 3'(i)) begin
        byte_nxt[i] = rx_byte;
      end
    end
    if (ctl.clear) begin
      idx_nxt = 4'd0;
      pid_nxt = new_id;
    end else if (wr_en) begin
      idx_nxt = idx_r + 4'd1;
    end
    if (ctl.chk) begin
      lost_nxt = lost_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        byte_r[i] <= 8'd0;
      end
      idx_r  <= 4'd0;
      pid_r  <= 8'd0;
      lost_r <= 16'd0;
    end else begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        byte_r[i] <= byte_nxt[i];
      end
      idx_r  <= idx_nxt;
      pid_r  <= pid_nxt;
      lost_r <= lost_nxt;
    end
  end

  `SRV_ASSERT_IMP(a_idx_bound, 1'b1, idx_r <= 4'(REPLY_LEN))
  `SRV_ASSERT_NXT(a_clear_idx, ctl.clear, idx_r == 4'd0)
  `SRV_ASSERT_NXT(a_lost_mono, 1'b1, lost_r >= $past(lost_r))

endmodule

`default_nettype wire

// ===== rtl/servo_register_read_transaction_top.sv =====
// Top level of the servo register read transaction block.
// Depends on srvrd_pkg, srvrd_reply and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A user feeds three kinds of input transaction, chosen by in_tuser. A read
// request (servo id, register address) clears the reply store and produces
// eight output transactions: the packet bytes FF FF id 04 02 addr 02 and the
// inverted byte sum, with out_tlast on the eighth. A reply byte produces no
// output; bytes are stored by position and anything past the eighth byte of
// the reply is dropped. A check produces one output transaction with
// out_tuser set: the little-endian register word from reply bytes 5 and 6
// and reply_ok high when the checksum and the servo id match, or zero with
// reply_ok low, in which case the saturating lost-reply count (reported in
// the same transaction) goes up by one. Missing reply bytes read as zero.
// Reply bytes and unused commands never wait; checks and request bytes
// wait while the output register holds a result not yet taken. A read
// request holds the input register until its last packet byte is sent,
// because every byte passes through the single output register. An input
// register and the output register separate the two channels, so an input
// transaction can be taken while a result still waits for out_tready. Each
// input passes through the input register, its output through the output register.
module servo_register_read_transaction_top
  import srvrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // target_id[7:0], reg_address[15:8], rx_byte[23:16]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // tx_byte[7:0], reg_value[23:8], reply_ok[24],
                                       // lost_count[40:25], zero fill[47:41]
  output logic             out_tlast,  // last
  output logic [0:0]       out_tuser   // kind[0]
);

  // Input register.
  logic       in_vld_r, in_vld_nxt;
  cmd_t       cmd_r;
  logic [7:0] id_r;
  logic [7:0] addr_r;
  logic [7:0] rxb_r;
  logic       in_take;

  // Request byte sequencer.
  logic [2:0] tx_cnt_r, tx_cnt_nxt;
  logic [7:0] req_byte;
  logic [7:0] req_sum;

  // Output register.
  logic        out_vld_r, out_vld_nxt;
  logic        out_kind_r;
  logic        out_last_r;
  logic [7:0]  out_tx_r;
  logic [15:0] out_val_r;
  logic        out_ok_r;
  logic [15:0] out_lost_r;
  logic        out_free;

  logic     emit;
  logic     done;
  rpl_ctl_t ctl;
  rpl_res_t res;

  assign in_take  = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;

  // Decide what the held transaction does this cycle.
  always_comb begin
    emit = 1'b0;
    done = 1'b0;
    ctl  = '0;
    if (in_vld_r) begin
      case (cmd_r)
        CMD_REQ: begin
          if (out_free) begin
            emit      = 1'b1;
            ctl.clear = (tx_cnt_r == 3'd0);
            done      = (tx_cnt_r == LAST_TX_IDX);
          end
        end
        CMD_RXB: begin
          ctl.wr = 1'b1;
          done   = 1'b1;
        end
        CMD_CHK: begin
          if (out_free) begin
            emit    = 1'b1;
            ctl.chk = 1'b1;
            done    = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  assign in_tready  = !in_vld_r || done;
  assign in_vld_nxt = in_take ? 1'b1 : (done ? 1'b0 : in_vld_r);

  // Packet checksum: inverted sum of id, length, instruction, address, size.
  assign req_sum = id_r + addr_r + 8'(PKT_LENGTH + INSTR_READ + READ_SIZE);

  always_comb begin
    case (tx_cnt_r)
      3'd0:    req_byte = SYNC_BYTE;
      3'd1:    req_byte = SYNC_BYTE;
      3'd2:    req_byte = id_r;
      3'd3:    req_byte = PKT_LENGTH;
      3'd4:    req_byte = INSTR_READ;
      3'd5:    req_byte = addr_r;
      3'd6:    req_byte = READ_SIZE;
      default: req_byte = ~req_sum;
    endcase
  end

  always_comb begin
    tx_cnt_nxt = tx_cnt_r;
    if (emit && cmd_r == CMD_REQ) begin
      tx_cnt_nxt = done ? 3'd0 : tx_cnt_r + 3'd1;
    end
  end

  assign out_vld_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);

  srvrd_reply u_reply (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .new_id  (id_r),
    .rx_byte (rxb_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      tx_cnt_r  <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      tx_cnt_r  <= tx_cnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r  <= cmd_t'(in_tuser);
      id_r   <= in_tdata[7:0];
      addr_r <= in_tdata[15:8];
      rxb_r  <= in_tdata[23:16];
    end
    if (emit) begin
      if (cmd_r == CMD_REQ) begin
        out_kind_r <= KIND_TX;
        out_last_r <= done;
        out_tx_r   <= req_byte;
        out_val_r  <= 16'd0;
        out_ok_r   <= 1'b0;
        out_lost_r <= 16'd0;
      end else begin
        out_kind_r <= KIND_CHK;
        out_last_r <= 1'b0;
        out_tx_r   <= 8'd0;
        out_val_r  <= res.value;
        out_ok_r   <= res.ok;
        out_lost_r <= res.lost;
      end
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {7'd0, out_lost_r, out_ok_r, out_val_r, out_tx_r};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_kind_r;

  `SRV_ASSERT_IMP(a_last_is_tx, out_vld_r && out_last_r, out_kind_r == KIND_TX)
  `SRV_ASSERT_IMP(a_seq_on_req, tx_cnt_r != 3'd0, in_vld_r && cmd_r == CMD_REQ)
  `SRV_ASSERT_IMP(a_stall_held, !in_tready, in_vld_r)

endmodule

`default_nettype wire

// ===== bench/tb_servo_register_read_transaction_top.sv =====
// Self-checking testbench for servo_register_read_transaction_top.
// Depends on srvrd_pkg and the block's RTL; it contains its own scoreboard class
// that predicts every output transaction.
`default_nettype none

module tb_servo_register_read_transaction_top;
  import srvrd_pkg::*;

  // The run is cut off here. A few hundred transactions are sent, each giving
  // at most eight output transactions, with idling and the long hold.
  localparam int unsigned CYCLE_LIMIT = 50_000;
  // Ready stays low this many cycles once during the random part.
  localparam int unsigned HOLD_CYCLES = 300;

  // One expected output transaction, split into its fields.
  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] reg_value;
    logic        reply_ok;
    logic [15:0] lost_count;
  } bus_result_t;

  // This class holds the predicted state of the read transaction engine and
  // the queue of output transactions that are still owed by the block.
  class servo_read_scoreboard;
    bus_result_t  owed_q[$];
    logic [7:0]   reply_store[STORE_DEPTH];
    logic [3:0]   reply_pos;
    logic [7:0]   last_id;
    logic [15:0]  lost_replies;
    int unsigned  errors;

    function new();
      foreach (reply_store[i]) reply_store[i] = 8'h00;
      reply_pos    = 4'd0;
      last_id      = 8'h00;
      lost_replies = 16'h0000;
      errors       = 0;
    endfunction

    // Records an accepted input transaction and queues the output it causes.
    function void note_input(cmd_t cmd, logic [7:0] id, logic [7:0] addr, logic [7:0] rx);
      bus_result_t r;
      logic [7:0]  pkt[REPLY_LEN];
      logic [7:0]  sum;
      logic [7:0]  inv;
      logic        ok;
      r = '0;
      case (cmd)
        CMD_REQ: begin
          foreach (reply_store[i]) reply_store[i] = 8'h00;
          reply_pos = 4'd0;
          last_id   = id;
          pkt[0] = SYNC_BYTE;
          pkt[1] = SYNC_BYTE;
          pkt[2] = id;
          pkt[3] = PKT_LENGTH;
          pkt[4] = INSTR_READ;
          pkt[5] = addr;
          pkt[6] = READ_SIZE;
          sum = 8'h00;
          for (int i = 2; i < 7; i++) sum = sum + pkt[i];
          pkt[7] = ~sum;
          for (int i = 0; i < REPLY_LEN; i++) begin
            r.kind    = KIND_TX;
            r.tx_byte = pkt[i];
            r.last    = (i == REPLY_LEN - 1);
            owed_q.push_back(r);
          end
        end
        CMD_RXB: begin
          // The two sync bytes only advance the position; anything past the
          // eighth byte is dropped.
          if (reply_pos < REPLY_LEN) begin
            if (reply_pos >= STORE_BASE) reply_store[reply_pos - STORE_BASE] = rx;
            reply_pos = reply_pos + 4'd1;
          end
        end
        CMD_CHK: begin
          sum = 8'h00;
          for (int i = 0; i < 5; i++) sum = sum + reply_store[i];
          inv = ~sum;
          ok  = (inv == reply_store[5]) && (reply_store[0] == last_id);
          if (ok) begin
            r.reg_value = {reply_store[4], reply_store[3]};
          end else if (lost_replies != 16'hFFFF) begin
            lost_replies = lost_replies + 16'd1;
          end
          r.kind       = KIND_CHK;
          r.reply_ok   = ok;
          r.lost_count = lost_replies;
          owed_q.push_back(r);
        end
        default: begin
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      end
    endfunction

    // Compares one accepted output transaction with the oldest one owed.
    function void check_result(logic [47:0] data, logic last, logic kind);
      bus_result_t want;
      if (owed_q.size() == 0) begin
        errors++;
        $error("unexpected output transaction: tdata 0x%0h tlast %0b tuser %0b",
               data, last, kind);
        return;
      end
      want = owed_q.pop_front();
      compare_field("kind", want.kind, kind);
      compare_field("tx_byte", want.tx_byte, data[7:0]);
      compare_field("last", want.last, last);
      compare_field("reg_value", want.reg_value, data[23:8]);
      compare_field("reply_ok", want.reply_ok, data[24]);
      compare_field("lost_count", want.lost_count, data[40:25]);
    endfunction
  endclass

  // Every input is known from time zero and driven only at rising edges.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // target_id[7:0], reg_address[15:8], rx_byte[23:16]
  logic [1:0]  in_tuser = CMD_NONE;  // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // tx_byte[7:0], reg_value[23:8], reply_ok[24], lost_count[40:25]
  logic        out_tlast;  // last
  logic [0:0]  out_tuser;  // kind[0]

  servo_read_scoreboard sb = new();

  // When calm is set, neither side idles. The stimulus sets hold_armed once
  // to make the receiver hold off for a long stretch.
  bit          calm = 1'b0;
  bit          hold_armed = 1'b0;
  int unsigned cycle_count = 0;

  servo_register_read_transaction_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Output monitor. Sampling at the edge sees the values from before the
  // edge, because the block and the ready driver both use nonblocking updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser[0]);
  end

  // Receiver. It is mostly ready and drops ready in about one cycle of ten.
  // It does not idle during the calm stretch. Once it is armed, it holds
  // ready low for a stretch set by HOLD_CYCLES, so the block fills up and
  // stalls its input.
  initial begin : receiver
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_tready <= 1'b0;
          @(posedge clk);
        end
      end
      out_tready <= calm || ($urandom_range(99) >= 10);
    end
  end

  // Offers one input transaction, with random idle cycles before it unless
  // the bench is calm, and returns at the edge where it is accepted. The
  // fields that the command does not use still carry whatever they are given.
  task automatic send_txn(cmd_t cmd, logic [7:0] id, logic [7:0] addr, logic [7:0] rx);
    while (!calm && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {rx, addr, id};
    do @(posedge clk); while (!in_tready);
    sb.note_input(cmd, id, addr, rx);
  endtask

  // Feeds the bytes of a servo reply. Only the first count bytes are sent,
  // and the unused request fields carry random values.
  task automatic send_reply(logic [7:0] bytes[10], int count);
    for (int i = 0; i < count; i++)
      send_txn(CMD_RXB, 8'($urandom), 8'($urandom), bytes[i]);
  endtask

  // Builds a well-formed status reply for the given id, carrying a register word.
  function automatic void build_reply(output logic [7:0] bytes[10], input logic [7:0] id,
                                      input logic [15:0] word, input logic [7:0] err);
    logic [7:0] sum;
    bytes[0] = SYNC_BYTE;
    bytes[1] = SYNC_BYTE;
    bytes[2] = id;
    bytes[3] = 8'h04;
    bytes[4] = err;
    bytes[5] = word[7:0];
    bytes[6] = word[15:8];
    sum = bytes[2] + bytes[3] + bytes[4] + bytes[5] + bytes[6];
    bytes[7] = ~sum;
    bytes[8] = 8'($urandom);
    bytes[9] = 8'($urandom);
  endfunction

  initial begin : stimulus
    logic [7:0]  reply[10];
    logic [7:0]  id;
    int          len;
    int unsigned mode;
    int unsigned rand_items;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first check comes before any request, so it uses
    // the reset id and an empty store.
    send_txn(CMD_CHK, 8'h00, 8'h00, 8'h00);
    send_txn(CMD_REQ, 8'h00, 8'h00, 8'h00);
    send_txn(CMD_CHK, 8'hFF, 8'hFF, 8'hFF);
    // Extreme id and address, then a good reply with a full-scale word,
    // one excess byte, and a repeated check of the same store.
    send_txn(CMD_REQ, 8'hFF, 8'hFF, 8'hFF);
    build_reply(reply, 8'hFF, 16'hFFFF, 8'h00);
    send_reply(reply, 9);
    send_txn(CMD_CHK, 8'h00, 8'h00, 8'h00);
    send_txn(CMD_CHK, 8'h5A, 8'hA5, 8'h3C);
    // The unused command has no effect.
    send_txn(CMD_NONE, 8'hFF, 8'hFF, 8'hFF);
    // A truncated reply. The bytes that are missing read as zero.
    send_txn(CMD_REQ, 8'h01, 8'h24, 8'h00);
    build_reply(reply, 8'h01, 16'h1234, 8'h00);
    send_reply(reply, 4);
    send_txn(CMD_CHK, 8'h01, 8'h24, 8'h00);

    // Random part. Most transactions make up whole request, reply and check
    // sequences. Some of those carry a wrong id, a wrong checksum, a short
    // reply or extra bytes. The rest are loose transactions of any command.
    hold_armed = 1'b1;
    rand_items = 0;
    while (rand_items < 300) begin
      calm = (rand_items >= 120) && (rand_items < 180);
      mode = $urandom_range(99);
      if (mode < 80) begin
        id = 8'($urandom);
        send_txn(CMD_REQ, id, 8'($urandom), 8'($urandom));
        build_reply(reply, id, 16'($urandom), 8'($urandom_range(3) == 0 ? $urandom : 0));
        len = 8;
        case ($urandom_range(9))
          0: reply[2] = reply[2] ^ 8'($urandom_range(255, 1));
          1: reply[7] = reply[7] ^ 8'($urandom_range(255, 1));
          2: len = $urandom_range(7);
          3: len = $urandom_range(10, 9);
          4: begin
            // The sync bytes are never checked.
            reply[0] = 8'($urandom);
            reply[1] = 8'($urandom);
          end
          default: begin
          end
        endcase
        send_reply(reply, len);
        send_txn(CMD_CHK, 8'($urandom), 8'($urandom), 8'($urandom));
        if ($urandom_range(4) == 0) send_txn(CMD_CHK, 8'($urandom), 8'($urandom), 8'($urandom));
        rand_items += 2 + len;
      end else begin
        send_txn(cmd_t'($urandom_range(3)), 8'($urandom), 8'($urandom), 8'($urandom));
        rand_items++;
      end
    end
    calm = 1'b0;

    in_tvalid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    // These extra cycles catch any stray output transaction.
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== servo_register_read_transaction_top.f =====
+incdir+rtl
rtl/srvrd_pkg.sv
rtl/srvrd_reply.sv
rtl/servo_register_read_transaction_top.sv
bench/tb_servo_register_read_transaction_top.sv
